@@ rtl/clcd_pkg.sv @@
package clcd_pkg;

    // Request kinds.
    typedef enum logic [2:0] {
        KIND_INIT        = 3'd0,
        KIND_DISP_CTRL   = 3'd1,
        KIND_CLEAR_DISP  = 3'd2,
        KIND_TEXT_CHAR   = 3'd3,
        KIND_CLEAR_LINE  = 3'd4
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int ROW_COUNT_RESET    = 2;
    localparam int COLUMN_COUNT_RESET = 16;

    localparam int DEF_LINE2_OFFSET = 64;
    localparam int DEF_MAX_COLUMNS  = 40;

    // Wide enough for any column limit and any column count.
    localparam int LIMIT_W = 7;

    localparam int WAIT_W = 17;
    localparam logic [WAIT_W-1:0] WAIT_FAST     = 17'd50;
    localparam logic [WAIT_W-1:0] WAIT_SLOW     = 17'd2000;
    localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 17'd100000;
    localparam logic [WAIT_W-1:0] WAIT_NIB_1    = 17'd9000;
    localparam logic [WAIT_W-1:0] WAIT_NIB_2    = 17'd200;

    // Command bytes.
    localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
    localparam logic [7:0] CMD_FUNC_N     = 8'h08;
    localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_INC  = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] NIB_WAKE       = 8'h03;
    localparam logic [7:0] NIB_4BIT       = 8'h02;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam logic [1:0] STROBE_NONE = 2'd0;
    localparam logic [1:0] STROBE_ONE  = 2'd1;
    localparam logic [1:0] STROBE_TWO  = 2'd2;

    localparam logic [3:0] INIT_LAST = 4'd8;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_byte;
        logic       line_select;
        logic       text_start;
        logic       display_enable;
        logic       cursor_enable;
        logic       cursor_blink;
    } t_req;

    typedef struct packed {
        logic              reg_select;
        logic [7:0]        bus_byte;
        logic [1:0]        strobe_count;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_res;

    typedef struct packed {
        logic capture;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic none;
        logic last;
        logic out_free;
    } t_dp_status;

    // Power-up sequence, one entry per transfer.
    function automatic t_res init_entry(input logic [3:0] idx, input logic one_row);
        t_res r;
        r = '0;
        case (idx)
            4'd0: begin
                r.wait_us = WAIT_POWER_UP;
            end
            4'd1: begin
                r.bus_byte = NIB_WAKE; r.strobe_count = STROBE_ONE; r.wait_us = WAIT_NIB_1;
            end
            4'd2: begin
                r.bus_byte = NIB_WAKE; r.strobe_count = STROBE_ONE; r.wait_us = WAIT_NIB_2;
            end
            4'd3: begin
                r.bus_byte = NIB_WAKE; r.strobe_count = STROBE_ONE; r.wait_us = WAIT_FAST;
            end
            4'd4: begin
                r.bus_byte = NIB_4BIT; r.strobe_count = STROBE_ONE; r.wait_us = WAIT_FAST;
            end
            4'd5: begin
                r.bus_byte     = one_row ? CMD_FUNC_SET : (CMD_FUNC_SET | CMD_FUNC_N);
                r.strobe_count = STROBE_TWO;
                r.wait_us      = WAIT_FAST;
            end
            4'd6: begin
                r.bus_byte = CMD_DISP_CTRL; r.strobe_count = STROBE_TWO; r.wait_us = WAIT_FAST;
            end
            4'd7: begin
                r.bus_byte = CMD_CLEAR; r.strobe_count = STROBE_TWO; r.wait_us = WAIT_SLOW;
            end
            4'd8: begin
                r.bus_byte = CMD_ENTRY_INC; r.strobe_count = STROBE_TWO; r.wait_us = WAIT_FAST;
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/clcd_if.sv @@
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_byte;
    logic       line_select;
    logic       text_start;
    logic       display_enable;
    logic       cursor_enable;
    logic       cursor_blink;

    modport source (output valid, kind, char_byte, line_select, text_start,
                    display_enable, cursor_enable, cursor_blink, input ready);
    modport sink   (input valid, kind, char_byte, line_select, text_start,
                    display_enable, cursor_enable, cursor_blink, output ready);
endinterface

interface clcd_res_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic [1:0]  strobe_count;
    logic [16:0] wait_us;
    logic        last;

    modport source (output valid, reg_select, bus_byte, strobe_count, wait_us, last,
                    input ready);
    modport sink   (input valid, reg_select, bus_byte, strobe_count, wait_us, last,
                    output ready);
endinterface

interface clcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/clcd_ctrl.sv @@
module clcd_ctrl #(
    parameter int STEP_W = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  clcd_pkg::t_dp_status   i_status,
    output clcd_pkg::t_ctrl_cmd    o_cmd,
    output logic [STEP_W-1:0]      o_step
);
    import clcd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_step      = r_step;

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd.capture = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_RUN;
                    n_step        = '0;
                end
            end
            ST_RUN: begin
                if (i_status.none) begin
                    n_state = ST_IDLE;
                    n_step  = '0;
                end else if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("transfer loaded into an occupied output register");

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == '0))
        else $error("step counter not cleared while idle");

    a_capture_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_RUN))
        else $error("captured request did not start a run");

    a_no_load_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.none |-> !o_cmd.load)
        else $error("transfer produced for an unknown request kind");

endmodule

@@ rtl/clcd_dp.sv @@
module clcd_dp #(
    parameter int LINE2_OFFSET = 64,
    parameter int MAX_COLUMNS  = 40,
    parameter int STEP_W       = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  clcd_pkg::t_req                     i_req,
    input  logic                               i_cfg_we,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  clcd_pkg::t_ctrl_cmd                i_cmd,
    input  logic [STEP_W-1:0]                  i_step,
    output clcd_pkg::t_dp_status               o_status,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output clcd_pkg::t_res                     o_res
);
    import clcd_pkg::*;

    localparam logic [6:0]         LINE2_ADDR = 7'(LINE2_OFFSET);
    localparam logic [LIMIT_W-1:0] COL_MAX    = LIMIT_W'(MAX_COLUMNS);

    logic [1:0]         r_row_count;
    logic [5:0]         r_column_count;
    t_req               r_req;
    logic               r_out_valid;
    t_res               r_out;

    t_res               n_res;
    t_res               w_init;
    logic               w_none;
    logic [7:0]         w_addr_byte;
    logic [LIMIT_W-1:0] w_col;
    logic [LIMIT_W-1:0] w_limit;
    logic               w_free;

    assign w_col       = LIMIT_W'(r_column_count);
    assign w_limit     = (w_col > COL_MAX) ? COL_MAX : w_col;
    assign w_addr_byte = CMD_SET_DDRAM | {1'b0, (r_req.line_select ? LINE2_ADDR : 7'd0)};
    assign w_init      = init_entry(i_step[3:0], r_row_count == 2'd1);
    assign w_free      = !r_out_valid || i_res_ready;

    always_comb begin
        n_res  = '0;
        w_none = 1'b0;
        case (r_req.kind)
            KIND_INIT: begin
                n_res      = w_init;
                n_res.last = (i_step == STEP_W'(INIT_LAST));
            end
            KIND_DISP_CTRL: begin
                n_res.bus_byte     = CMD_DISP_CTRL | {5'd0, r_req.display_enable,
                                                      r_req.cursor_enable, r_req.cursor_blink};
                n_res.strobe_count = STROBE_TWO;
                n_res.wait_us      = WAIT_FAST;
                n_res.last         = 1'b1;
            end
            KIND_CLEAR_DISP: begin
                n_res.bus_byte     = CMD_CLEAR;
                n_res.strobe_count = STROBE_TWO;
                n_res.wait_us      = WAIT_SLOW;
                n_res.last         = 1'b1;
            end
            KIND_TEXT_CHAR: begin
                n_res.strobe_count = STROBE_TWO;
                n_res.wait_us      = WAIT_FAST;
                if (r_req.text_start && (i_step == '0)) begin
                    n_res.bus_byte = w_addr_byte;
                end else begin
                    n_res.reg_select = 1'b1;
                    n_res.bus_byte   = r_req.char_byte;
                    n_res.last       = 1'b1;
                end
            end
            KIND_CLEAR_LINE: begin
                n_res.strobe_count = STROBE_TWO;
                n_res.wait_us      = WAIT_FAST;
                if (i_step == '0) begin
                    n_res.bus_byte = w_addr_byte;
                end else begin
                    n_res.reg_select = 1'b1;
                    n_res.bus_byte   = CHAR_SPACE;
                end
                // Address plus one space per column; the step equals the limit on the last.
                n_res.last = (LIMIT_W'(i_step) == w_limit);
            end
            default: begin
                w_none = 1'b1;
            end
        endcase
    end

    assign o_status.none     = w_none;
    assign o_status.last     = n_res.last;
    assign o_status.out_free = w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= 2'(ROW_COUNT_RESET);
            r_column_count <= 6'(COLUMN_COUNT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROW_COUNT) begin
                r_row_count <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_COLUMN_COUNT) begin
                r_column_count <= i_cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.load) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ rtl/char_lcd_nibble_sequencer.sv @@
// Channel   Direction  Beat contents
// i_req     in         kind, char_byte, line_select, text_start, display/cursor bits
// o_res     out        reg_select, bus_byte, strobe_count, wait_us, last
// i_cfg     in         index (0 row_count, 1 column_count), data
//
// A request beat is taken while idle; the sequencer then loads one transfer per
// cycle into the output register while it is free: 9 transfers for power-up,
// column_count + 1 for clear line (at most MAX_COLUMNS + 1), and none for an
// unknown kind, which returns the sequencer to idle.
// The next request is taken once the last transfer is loaded, even if it still waits.
// Reset sets row_count to 2 and column_count to 16; there is no clearing pass.
// Back-pressure on o_res holds the register and pauses the step counter.
module char_lcd_nibble_sequencer #(
    parameter int LINE2_OFFSET = clcd_pkg::DEF_LINE2_OFFSET,
    parameter int MAX_COLUMNS  = clcd_pkg::DEF_MAX_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clcd_req_if.sink    i_req,
    clcd_res_if.source  o_res,
    clcd_cfg_if.sink    i_cfg
);
    import clcd_pkg::*;

    localparam int STEP_W = $clog2(MAX_COLUMNS + 1);

    t_req              w_req;
    t_res              w_res;
    t_ctrl_cmd         w_cmd;
    t_dp_status        w_status;
    logic [STEP_W-1:0] w_step;
    logic              w_req_ready;
    logic              w_res_valid;

    assign w_req.kind           = i_req.kind;
    assign w_req.char_byte      = i_req.char_byte;
    assign w_req.line_select    = i_req.line_select;
    assign w_req.text_start     = i_req.text_start;
    assign w_req.display_enable = i_req.display_enable;
    assign w_req.cursor_enable  = i_req.cursor_enable;
    assign w_req.cursor_blink   = i_req.cursor_blink;
    assign i_req.ready          = w_req_ready;

    assign i_cfg.ready = 1'b1;

    clcd_ctrl #(
        .STEP_W (STEP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_step      (w_step)
    );

    clcd_dp #(
        .LINE2_OFFSET (LINE2_OFFSET),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .STEP_W       (STEP_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .i_step      (w_step),
        .o_status    (w_status),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign o_res.valid        = w_res_valid;
    assign o_res.reg_select   = w_res.reg_select;
    assign o_res.bus_byte     = w_res.bus_byte;
    assign o_res.strobe_count = w_res.strobe_count;
    assign o_res.wait_us      = w_res.wait_us;
    assign o_res.last         = w_res.last;

endmodule

@@ verif/char_lcd_nibble_sequencer_tb.sv @@
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_tb;

    import clcd_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 56;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Kind codes that the sequencer does not know.
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // Register indexes with no register behind them.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [7:0] LINE1_ADDR = 8'h00;
    localparam logic [7:0] LINE2_ADDR = 8'(DEF_LINE2_OFFSET) & 8'h7f;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    clcd_req_if req_bus ();
    clcd_res_if res_bus ();
    clcd_cfg_if cfg_bus ();

    char_lcd_nibble_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    t_req request_queue[$];
    t_res expected_transfers[$];

    logic [1:0] row_setting    = 2'(ROW_COUNT_RESET);
    logic [5:0] column_setting = 6'(COLUMN_COUNT_RESET);

    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int failures          = 0;
    int requests_taken    = 0;
    int transfers_checked = 0;
    int settings_run      = 1;
    int cycles            = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        req_bus.valid          = 1'b0;
        req_bus.kind           = '0;
        req_bus.char_byte      = '0;
        req_bus.line_select    = 1'b0;
        req_bus.text_start     = 1'b0;
        req_bus.display_enable = 1'b0;
        req_bus.cursor_enable  = 1'b0;
        req_bus.cursor_blink   = 1'b0;
        res_bus.ready          = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
    end

    function automatic void push_transfer(input logic rs, input logic [7:0] bus_val,
                                          input logic [1:0] strobes,
                                          input logic [WAIT_W-1:0] wait_val);
        t_res t;
        t.reg_select   = rs;
        t.bus_byte     = bus_val;
        t.strobe_count = strobes;
        t.wait_us      = wait_val;
        t.last         = 1'b0;
        expected_transfers.push_back(t);
    endfunction

    // Expands one request into the bus transfers that the display needs.
    function automatic void expand_request(input t_req rq);
        int         prior_size;
        int         spaces;
        logic [7:0] ddram;
        prior_size = expected_transfers.size();
        ddram      = CMD_SET_DDRAM | (rq.line_select ? LINE2_ADDR : LINE1_ADDR);
        case (rq.kind)
            KIND_INIT: begin
                push_transfer(RS_CMD, 8'h00, STROBE_NONE, WAIT_POWER_UP);
                push_transfer(RS_CMD, NIB_WAKE, STROBE_ONE, WAIT_NIB_1);
                push_transfer(RS_CMD, NIB_WAKE, STROBE_ONE, WAIT_NIB_2);
                push_transfer(RS_CMD, NIB_WAKE, STROBE_ONE, WAIT_FAST);
                push_transfer(RS_CMD, NIB_4BIT, STROBE_ONE, WAIT_FAST);
                push_transfer(RS_CMD, (row_setting == 2'd1) ? CMD_FUNC_SET
                                      : (CMD_FUNC_SET | CMD_FUNC_N), STROBE_TWO, WAIT_FAST);
                push_transfer(RS_CMD, CMD_DISP_CTRL, STROBE_TWO, WAIT_FAST);
                push_transfer(RS_CMD, CMD_CLEAR, STROBE_TWO, WAIT_SLOW);
                push_transfer(RS_CMD, CMD_ENTRY_INC, STROBE_TWO, WAIT_FAST);
            end
            KIND_DISP_CTRL: begin
                push_transfer(RS_CMD, CMD_DISP_CTRL | {5'b0, rq.display_enable,
                              rq.cursor_enable, rq.cursor_blink}, STROBE_TWO, WAIT_FAST);
            end
            KIND_CLEAR_DISP: begin
                push_transfer(RS_CMD, CMD_CLEAR, STROBE_TWO, WAIT_SLOW);
            end
            KIND_TEXT_CHAR: begin
                if (rq.text_start) begin
                    push_transfer(RS_CMD, ddram, STROBE_TWO, WAIT_FAST);
                end
                push_transfer(RS_DATA, rq.char_byte, STROBE_TWO, WAIT_FAST);
            end
            KIND_CLEAR_LINE: begin
                spaces = (column_setting > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                            : int'(column_setting);
                push_transfer(RS_CMD, ddram, STROBE_TWO, WAIT_FAST);
                for (int i = 0; i < spaces; i++) begin
                    push_transfer(RS_DATA, CHAR_SPACE, STROBE_TWO, WAIT_FAST);
                end
            end
            default: begin
            end
        endcase
        if (expected_transfers.size() > prior_size) begin
            expected_transfers[expected_transfers.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic t_req random_fields();
        t_req rq;
        rq = t_req'($urandom);
        return rq;
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic line, input logic start,
                                      input logic [2:0] dcb);
        t_req rq;
        rq                = random_fields();
        rq.kind           = kind;
        rq.char_byte      = ch;
        rq.line_select    = line;
        rq.text_start     = start;
        rq.display_enable = dcb[2];
        rq.cursor_enable  = dcb[1];
        rq.cursor_blink   = dcb[0];
        return rq;
    endfunction

    // Request driver: a beat is held until taken, then the next one follows.
    always @(posedge i_clk) begin
        t_req nxt;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                expand_request(request_queue.pop_front());
                requests_taken++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt                     = request_queue[0];
                    req_bus.kind           <= nxt.kind;
                    req_bus.char_byte      <= nxt.char_byte;
                    req_bus.line_select    <= nxt.line_select;
                    req_bus.text_start     <= nxt.text_start;
                    req_bus.display_enable <= nxt.display_enable;
                    req_bus.cursor_enable  <= nxt.cursor_enable;
                    req_bus.cursor_blink   <= nxt.cursor_blink;
                    req_bus.valid          <= 1'b1;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Transfer monitor.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_transfers.size() == 0) begin
                    $error("unexpected transfer: bus_byte %0h, last %0b",
                           res_bus.bus_byte, res_bus.last);
                    failures++;
                end else begin
                    want = expected_transfers.pop_front();
                    transfers_checked++;
                    if (res_bus.reg_select !== want.reg_select) begin
                        $error("reg_select: expected %0d, got %0d",
                               want.reg_select, res_bus.reg_select);
                        failures++;
                    end
                    if (res_bus.bus_byte !== want.bus_byte) begin
                        $error("bus_byte: expected %0h, got %0h",
                               want.bus_byte, res_bus.bus_byte);
                        failures++;
                    end
                    if (res_bus.strobe_count !== want.strobe_count) begin
                        $error("strobe_count: expected %0d, got %0d",
                               want.strobe_count, res_bus.strobe_count);
                        failures++;
                    end
                    if (res_bus.wait_us !== want.wait_us) begin
                        $error("wait_us: expected %0d, got %0d",
                               want.wait_us, res_bus.wait_us);
                        failures++;
                    end
                    if (res_bus.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_bus.last);
                        failures++;
                    end
                end
            end
            res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timed out with %0d transfers outstanding.", expected_transfers.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (request_queue.size() > 0 || req_bus.valid || expected_transfers.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_ROW_COUNT:    row_setting    = value[1:0];
            CFG_COLUMN_COUNT: column_setting = value[5:0];
            default: begin
            end
        endcase
    endtask

    // Mostly whole texts (address first, then characters), with the other
    // commands and some unknown kinds mixed in.
    task automatic queue_random_requests(input int target);
        int   queued;
        int   pick;
        int   len;
        t_req rq;
        logic line;
        queued = 0;
        while (queued < target) begin
            pick = $urandom_range(99);
            rq   = random_fields();
            if (pick < 4) begin
                rq.kind = KIND_INIT;
            end else if (pick < 14) begin
                rq.kind = KIND_DISP_CTRL;
            end else if (pick < 20) begin
                rq.kind = KIND_CLEAR_DISP;
            end else if (pick < 28) begin
                rq.kind = KIND_CLEAR_LINE;
            end else if (pick < 32) begin
                rq.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
            if (pick < 32) begin
                request_queue.push_back(rq);
                if (pick >= 28) begin
                    queued--;
                end
                queued++;
            end else begin
                len  = $urandom_range(1, 8);
                line = 1'($urandom_range(1));
                for (int i = 0; i < len; i++) begin
                    rq             = random_fields();
                    rq.kind        = KIND_TEXT_CHAR;
                    rq.line_select = line;
                    // A text now and then lacks its address, or restarts midway.
                    rq.text_start  = (pick < 90) ? (i == 0) : rq.text_start;
                    request_queue.push_back(rq);
                    queued++;
                end
            end
        end
    endtask

    initial begin
        logic [1:0] rows;
        logic [5:0] cols;
        logic [7:0] value;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings.
        request_queue.push_back(make_req(KIND_INIT, 8'h00, 1'b0, 1'b0, 3'b000));
        for (int i = 0; i < 8; i++) begin
            request_queue.push_back(make_req(KIND_DISP_CTRL, 8'h00, 1'b0, 1'b0, 3'(i)));
        end
        request_queue.push_back(make_req(KIND_CLEAR_DISP, 8'h00, 1'b0, 1'b0, 3'b000));
        request_queue.push_back(make_req(KIND_TEXT_CHAR, 8'h00, 1'b0, 1'b1, 3'b000));
        request_queue.push_back(make_req(KIND_TEXT_CHAR, 8'hff, 1'b0, 1'b0, 3'b111));
        request_queue.push_back(make_req(KIND_TEXT_CHAR, 8'h41, 1'b1, 1'b1, 3'b000));
        request_queue.push_back(make_req(KIND_TEXT_CHAR, 8'h7e, 1'b1, 1'b0, 3'b101));
        request_queue.push_back(make_req(KIND_TEXT_CHAR, 8'h80, 1'b1, 1'b1, 3'b010));
        request_queue.push_back(make_req(KIND_CLEAR_LINE, 8'h00, 1'b0, 1'b0, 3'b000));
        request_queue.push_back(make_req(KIND_CLEAR_LINE, 8'hff, 1'b1, 1'b1, 3'b111));
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
            request_queue.push_back(make_req(3'(k), 8'h5a, 1'b1, 1'b1, 3'b111));
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_quiet();
            case (phase)
                0: begin rows = 2'd1; cols = 6'd1;  end
                1: begin rows = 2'd2; cols = 6'd40; end
                2: begin rows = 2'd0; cols = 6'd0;  end
                3: begin rows = 2'd3; cols = 6'd63; end
                4: begin rows = 2'd1; cols = 6'd41; end
                5: begin rows = 2'd2; cols = 6'd16; end
                default: begin
                    rows = 2'($urandom_range(3));
                    cols = 6'($urandom_range(63));
                end
            endcase
            value      = 8'($urandom);
            value[1:0] = rows;
            write_register(CFG_ROW_COUNT, value);
            value      = 8'($urandom);
            value[5:0] = cols;
            write_register(CFG_COLUMN_COUNT, value);
            if (phase == 2) begin
                write_register(2'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
            end
            settings_run++;
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            queue_random_requests(PHASE_ITEMS);
        end
        wait_quiet();

        $display("Ran %0d requests of every kind over %0d register settings",
                 requests_taken, settings_run);
        $display("and four idling modes; checked %0d bus transfers, %0d mismatches.",
                 transfers_checked, failures);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
